FILE: rtl/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg: shared types and constants of the peer liveness probe table
// Beat structs, slot record, request and result codes, saturating time add.
// ----------------------------------------------------------------------------
package plt_pkg;

    localparam int ENTRIES   = 16;
    localparam int ID_BITS   = 64;
    localparam int TIME_BITS = 48;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int SUM_W     = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
    localparam int REM_CW    = $clog2(TIME_BITS + 1);

    localparam logic [31:0] IVL_RST = 32'd1000;
    localparam logic [31:0] TMO_RST = 32'd3000;

    localparam logic REG_IVL = 1'b0;
    localparam logic REG_TMO = 1'b1;

    localparam logic [2:0] REQ_ADMIT      = 3'd0;
    localparam logic [2:0] REQ_DISCONNECT = 3'd1;
    localparam logic [2:0] REQ_ACK        = 3'd2;
    localparam logic [2:0] REQ_CHECK      = 3'd3;
    localparam logic [2:0] REQ_TICK       = 3'd4;

    localparam logic [1:0] KIND_REPLY    = 2'd0;
    localparam logic [1:0] KIND_PROBE    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT  = 2'd2;
    localparam logic [1:0] KIND_TICK_END = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] node_id;
        logic [63:0] conn_id;
        logic [63:0] probe_tag;
        logic [47:0] now;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic [63:0] out_node;
        logic [63:0] out_conn;
        logic [63:0] out_probe;
        logic        last;
        logic [4:0]  peer_count;
        logic [47:0] next_due;
        logic        next_due_valid;
    } t_out_beat;

    typedef struct packed {
        logic valid;
        logic pending;
        logic ev_to;
        logic ev_probe;
    } t_slot_ctl;

    typedef struct packed {
        logic [ID_BITS-1:0]   node;
        logic [ID_BITS-1:0]   conn;
        logic [TIME_BITS-1:0] deadline;
        logic [TIME_BITS-1:0] probe_due;
        logic [ID_BITS-1:0]   pending_id;
    } t_slot_dat;

    typedef struct packed {
        t_slot_ctl ctl;
        t_slot_dat dat;
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_APPLY,
        ST_REPLY,
        ST_EMIT,
        ST_END
    } t_state;

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                      input logic [31:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s > SUM_W'({TIME_BITS{1'b1}})) begin
            return {TIME_BITS{1'b1}};
        end
        return TIME_BITS'(s);
    endfunction

endpackage

FILE: rtl/plt_cell.sv
// ----------------------------------------------------------------------------
// plt_cell: one slot of the peer table ring
// Holds one slot record and takes its neighbor's record on each shift.
// ----------------------------------------------------------------------------
module plt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  plt_pkg::t_slot i_rec,
    output plt_pkg::t_slot o_rec
);
    import plt_pkg::*;

    t_slot_ctl r_ctl;
    t_slot_dat r_dat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_shift) begin
            r_ctl <= i_rec.ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_dat <= i_rec.dat;
        end
    end

    assign o_rec = '{ctl: r_ctl, dat: r_dat};

endmodule

FILE: rtl/plt_rem.sv
// ----------------------------------------------------------------------------
// plt_rem: bit-serial remainder unit
// Restoring division, one numerator bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module plt_rem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [plt_pkg::TIME_BITS-1:0] i_num,
    input  logic [31:0]                   i_den,
    output logic                          o_done,
    output logic [31:0]                   o_rem
);
    import plt_pkg::*;

    logic              r_busy;
    logic [REM_CW-1:0] r_cnt;
    logic [31:0]       r_rem;
    logic [31:0]       r_den;
    logic [TIME_BITS-1:0] r_num;
    logic [32:0]       t;
    logic              ge;

    assign t  = {r_rem, r_num[TIME_BITS-1]};
    assign ge = t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= REM_CW'(TIME_BITS);
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= ge ? 32'(t - {1'b0, r_den}) : 32'(t);
            r_num <= r_num << 1;
        end
    end

    assign o_done = r_busy && r_cnt == '0;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/peer_liveness_probe_table_top.sv
// ----------------------------------------------------------------------------
// peer_liveness_probe_table_top: keepalive and heartbeat timeout table
// Ring of slot cells walked by a head sequencer, with APB register port.
// ----------------------------------------------------------------------------
// Requests enter on i_in_valid/o_in_ready as one beat; results leave on
// o_out_valid/i_out_ready. Admit, disconnect, acknowledge and check give one
// reply beat; a tick gives one beat per timed-out or probed peer in slot
// order, then a tick end beat. The last beat of a request has last set.
// The slot records sit in a ring of cells that rotates past a head unit.
// A request takes two full turns of the ring, a scan turn and then an
// apply or emit turn, before its reply or tick end beat. During the scan
// of a tick the ring waits at each peer whose probe is due while the
// bit-serial remainder unit runs; the emit turn gives the result beats.
// The output register lets the next request be taken while a reply waits.
// When the receiver stalls, the ring holds during the result turn.
// Reset empties the table, clears the probe counter and loads the
// register defaults (interval 1000, timeout 3000); it is synchronous.
// Registers: probe interval at 0x0, peer timeout at 0x4, written with
// psel, penable and pwrite high; pready is always high.
// ----------------------------------------------------------------------------
module peer_liveness_probe_table_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  plt_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output plt_pkg::t_out_beat o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import plt_pkg::*;

    t_state    r_state, n_state;
    t_in_beat  r_req;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic      r_match_hit, n_match_hit;
    logic [IDX_W-1:0] r_match_idx, n_match_idx;
    logic      r_free_hit, n_free_hit;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;
    logic      r_ok, n_ok;
    logic [CNT_W-1:0] r_count, n_count;
    logic [TIME_BITS-1:0] r_due, n_due;
    logic      r_due_ok, n_due_ok;
    logic [ID_BITS-1:0] r_pcnt, n_pcnt;
    logic [31:0] r_ivl_ms, r_tmo_ms;
    logic      r_out_valid;
    t_out_beat r_out;

    t_slot     chain [ENTRIES];
    t_slot     h, wb;
    logic      shift, agg, rem_start, rem_done, out_load, can_load;
    logic [31:0] rem, iv;
    t_out_beat out_beat;

    logic [ID_BITS-1:0]   q_node, q_conn, q_pid, new_id;
    logic [TIME_BITS-1:0] q_now, c_due;
    logic [IDX_W-1:0]     adm_tgt;
    logic                 adm_ok, last_slot;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ivl_ms <= IVL_RST;
            r_tmo_ms <= TMO_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_IVL) begin
                r_ivl_ms <= pwdata;
            end else begin
                r_tmo_ms <= pwdata;
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TMO) ? r_tmo_ms : r_ivl_ms;
    assign iv     = (r_ivl_ms == '0) ? 32'd1 : r_ivl_ms;

    // slot ring
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        if (k == ENTRIES - 1) begin : g_tail
            plt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_rec   (wb),
                .o_rec   (chain[k])
            );
        end else begin : g_body
            plt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_rec   (chain[k+1]),
                .o_rec   (chain[k])
            );
        end
    end

    assign h = chain[0];

    plt_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_num   (q_now - h.dat.probe_due),
        .i_den   (iv),
        .o_done  (rem_done),
        .o_rem   (rem)
    );

    assign q_node    = r_req.node_id[ID_BITS-1:0];
    assign q_conn    = r_req.conn_id[ID_BITS-1:0];
    assign q_pid     = r_req.probe_tag[ID_BITS-1:0];
    assign q_now     = r_req.now[TIME_BITS-1:0];
    assign adm_ok    = q_node != '0 && q_conn != '0 && (r_match_hit || r_free_hit);
    assign adm_tgt   = r_match_hit ? r_match_idx : r_free_idx;
    assign last_slot = r_idx == IDX_W'(ENTRIES - 1);
    assign new_id    = (r_pcnt == '0) ? ID_BITS'(1) : r_pcnt;
    assign can_load  = !r_out_valid || i_out_ready;
    assign c_due     = (wb.dat.deadline < wb.dat.probe_due) ? wb.dat.deadline
                                                             : wb.dat.probe_due;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pcnt  <= n_pcnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_req <= i_in_data;
        end
        if (out_load) begin
            r_out <= out_beat;
        end
        r_idx       <= n_idx;
        r_match_hit <= n_match_hit;
        r_match_idx <= n_match_idx;
        r_free_hit  <= n_free_hit;
        r_free_idx  <= n_free_idx;
        r_ok        <= n_ok;
        r_count     <= n_count;
        r_due       <= n_due;
        r_due_ok    <= n_due_ok;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_match_hit = r_match_hit;
        n_match_idx = r_match_idx;
        n_free_hit  = r_free_hit;
        n_free_idx  = r_free_idx;
        n_ok        = r_ok;
        n_count     = r_count;
        n_due       = r_due;
        n_due_ok    = r_due_ok;
        n_pcnt      = r_pcnt;
        wb          = h;
        wb.ctl.ev_to    = 1'b0;
        wb.ctl.ev_probe = 1'b0;
        shift       = 1'b0;
        agg         = 1'b0;
        rem_start   = 1'b0;
        out_load    = 1'b0;
        out_beat    = '0;
        out_beat.ok             = 1'b1;
        out_beat.peer_count     = 5'(r_count);
        out_beat.next_due       = 48'(r_due);
        out_beat.next_due_valid = r_due_ok;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state     = ST_SCAN;
                    n_idx       = '0;
                    n_match_hit = 1'b0;
                    n_free_hit  = 1'b0;
                    n_ok        = 1'b0;
                    n_count     = '0;
                    n_due       = '0;
                    n_due_ok    = 1'b0;
                end
            end
            ST_SCAN: begin
                if (r_req.req_type == REQ_TICK) begin
                    if (h.ctl.valid && h.dat.deadline <= q_now) begin
                        wb.ctl.valid = 1'b0;
                        wb.ctl.ev_to = 1'b1;
                        shift        = 1'b1;
                    end else if (h.ctl.valid && h.dat.probe_due <= q_now) begin
                        rem_start = 1'b1;
                        n_state   = ST_DIV;
                    end else begin
                        shift = 1'b1;
                        agg   = 1'b1;
                    end
                end else begin
                    shift = 1'b1;
                    if (h.ctl.valid && h.dat.node == q_node && !r_match_hit) begin
                        n_match_hit = 1'b1;
                        n_match_idx = r_idx;
                    end
                    if (!h.ctl.valid && !r_free_hit) begin
                        n_free_hit = 1'b1;
                        n_free_idx = r_idx;
                    end
                end
                if (shift) begin
                    n_idx = r_idx + 1'b1;
                    if (last_slot) begin
                        n_idx   = '0;
                        n_state = (r_req.req_type == REQ_TICK) ? ST_EMIT : ST_APPLY;
                    end
                end
            end
            ST_DIV: begin
                if (rem_done) begin
                    if (!h.ctl.pending) begin
                        wb.ctl.pending    = 1'b1;
                        wb.dat.pending_id = new_id;
                        n_pcnt            = new_id + 1'b1;
                    end
                    wb.dat.probe_due = sat_add(q_now - TIME_BITS'(rem), iv);
                    wb.ctl.ev_probe  = 1'b1;
                    shift   = 1'b1;
                    agg     = 1'b1;
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_SCAN;
                    if (last_slot) begin
                        n_idx   = '0;
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_APPLY: begin
                shift = 1'b1;
                agg   = 1'b1;
                unique case (r_req.req_type)
                    REQ_ADMIT: begin
                        if (adm_ok && r_idx == adm_tgt) begin
                            wb.ctl.valid      = 1'b1;
                            wb.ctl.pending    = 1'b0;
                            wb.dat.node       = q_node;
                            wb.dat.conn       = q_conn;
                            wb.dat.deadline   = sat_add(q_now, r_tmo_ms);
                            wb.dat.probe_due  = sat_add(q_now, iv);
                            wb.dat.pending_id = '0;
                            n_ok              = 1'b1;
                        end
                    end
                    REQ_DISCONNECT: begin
                        if (r_match_hit && r_idx == r_match_idx && h.dat.conn == q_conn) begin
                            wb.ctl.valid = 1'b0;
                            n_ok         = 1'b1;
                        end
                    end
                    REQ_ACK: begin
                        if (r_match_hit && r_idx == r_match_idx && h.dat.conn == q_conn
                            && h.ctl.pending && h.dat.pending_id == q_pid) begin
                            wb.ctl.pending  = 1'b0;
                            wb.dat.deadline = sat_add(q_now, r_tmo_ms);
                            n_ok            = 1'b1;
                        end
                    end
                    REQ_CHECK: begin
                        if (q_pid != '0 && r_match_hit && r_idx == r_match_idx
                            && h.dat.conn == q_conn) begin
                            n_ok = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                n_idx = r_idx + 1'b1;
                if (last_slot) begin
                    n_idx   = '0;
                    n_state = ST_REPLY;
                end
            end
            ST_REPLY: begin
                out_beat.kind = KIND_REPLY;
                out_beat.ok   = r_ok;
                out_beat.last = 1'b1;
                if (r_req.req_type == REQ_CHECK && r_ok) begin
                    out_beat.out_node  = 64'(q_node);
                    out_beat.out_conn  = 64'(q_conn);
                    out_beat.out_probe = 64'(q_pid);
                end
                if (can_load) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_EMIT: begin
                out_beat.kind     = h.ctl.ev_to ? KIND_TIMEOUT : KIND_PROBE;
                out_beat.out_node = 64'(h.dat.node);
                if (h.ctl.ev_probe) begin
                    out_beat.out_conn  = 64'(h.dat.conn);
                    out_beat.out_probe = 64'(h.dat.pending_id);
                end
                if (h.ctl.ev_to || h.ctl.ev_probe) begin
                    out_load = can_load;
                    shift    = can_load;
                end else begin
                    shift = 1'b1;
                end
                if (shift) begin
                    n_idx = r_idx + 1'b1;
                    if (last_slot) begin
                        n_idx   = '0;
                        n_state = ST_END;
                    end
                end
            end
            ST_END: begin
                out_beat.kind = KIND_TICK_END;
                out_beat.last = 1'b1;
                if (can_load) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (agg && wb.ctl.valid) begin
            n_count = r_count + 1'b1;
            if (!r_due_ok || c_due < r_due) begin
                n_due    = c_due;
                n_due_ok = 1'b1;
            end
        end
    end

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.peer_count <= 5'(ENTRIES))
        else $error("peer count above table size");

    a_due_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.next_due_valid == (o_out_data.peer_count != '0)))
        else $error("next_due_valid disagrees with peer count");

    a_rem_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_done |-> r_state == ST_DIV)
        else $error("remainder done outside probe update");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == ST_SCAN)
        else $error("accepted beat did not start a scan");

endmodule

FILE: dv/plt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plt_checker: beat predictor and result comparator for the probe table
// Watches the request, result and register channels. Keeps its own copy of
// the peer table, probe counter and registers. For each accepted request it
// works out the result beats and checks each result beat, field by field,
// against the oldest one outstanding.
// ----------------------------------------------------------------------------
module plt_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  plt_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  plt_pkg::t_out_beat i_out_data,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_outstanding,
    output logic [63:0]        o_last_probe
);
    import plt_pkg::*;

    logic [31:0] interval_q;
    logic [31:0] timeout_q;
    logic        peer_valid   [ENTRIES];
    logic [63:0] peer_node    [ENTRIES];
    logic [63:0] peer_conn    [ENTRIES];
    logic [47:0] peer_deadline[ENTRIES];
    logic [47:0] peer_probe_at[ENTRIES];
    logic        peer_pending [ENTRIES];
    logic [63:0] peer_pend_id [ENTRIES];
    logic [63:0] probe_ctr;
    t_out_beat   expected_beats[$];
    int          fails;

    assign o_fail_count  = fails;
    assign o_outstanding = expected_beats.size();
    assign o_last_probe  = probe_ctr;

    function automatic logic [47:0] time_sum(input logic [47:0] a, input logic [31:0] b);
        logic [63:0] s;
        s = 64'(a) + 64'(b);
        return (s > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    function automatic int find_peer(input logic [63:0] node);
        for (int i = 0; i < ENTRIES; i++) begin
            if (peer_valid[i] && peer_node[i] == node) return i;
        end
        return -1;
    endfunction

    task automatic predict_beats(input t_in_beat b);
        t_out_beat   res[$];
        t_out_beat   r;
        int          s;
        int          cnt;
        logic [31:0] iv;
        logic [63:0] diff;
        logic [47:0] due;
        logic [47:0] c;
        logic        due_ok;
        iv = (interval_q == 0) ? 32'd1 : interval_q;
        r = '0;
        r.kind = KIND_REPLY;
        case (b.req_type)
            REQ_ADMIT: begin
                if (b.node_id != 0 && b.conn_id != 0) begin
                    s = find_peer(b.node_id);
                    for (int i = 0; i < ENTRIES && s < 0; i++) begin
                        if (!peer_valid[i]) s = i;
                    end
                    if (s >= 0) begin
                        peer_valid[s]    = 1'b1;
                        peer_node[s]     = b.node_id;
                        peer_conn[s]     = b.conn_id;
                        peer_deadline[s] = time_sum(b.now, timeout_q);
                        peer_probe_at[s] = time_sum(b.now, iv);
                        peer_pending[s]  = 1'b0;
                        peer_pend_id[s]  = '0;
                        r.ok = 1'b1;
                    end
                end
                res.insert(res.size(), r);
            end
            REQ_DISCONNECT: begin
                s = find_peer(b.node_id);
                if (s >= 0 && peer_conn[s] == b.conn_id) begin
                    peer_valid[s] = 1'b0;
                    r.ok = 1'b1;
                end
                res.insert(res.size(), r);
            end
            REQ_ACK: begin
                s = find_peer(b.node_id);
                if (s >= 0 && peer_conn[s] == b.conn_id && peer_pending[s]
                    && peer_pend_id[s] == b.probe_tag) begin
                    peer_pending[s]  = 1'b0;
                    peer_deadline[s] = time_sum(b.now, timeout_q);
                    r.ok = 1'b1;
                end
                res.insert(res.size(), r);
            end
            REQ_CHECK: begin
                s = (b.probe_tag != 0) ? find_peer(b.node_id) : -1;
                if (s >= 0 && peer_conn[s] == b.conn_id) begin
                    r.ok        = 1'b1;
                    r.out_node  = b.node_id;
                    r.out_conn  = b.conn_id;
                    r.out_probe = b.probe_tag;
                end
                res.insert(res.size(), r);
            end
            REQ_TICK: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!peer_valid[i]) continue;
                    r = '0;
                    r.ok = 1'b1;
                    if (peer_deadline[i] <= b.now) begin
                        r.kind     = KIND_TIMEOUT;
                        r.out_node = peer_node[i];
                        res.insert(res.size(), r);
                        peer_valid[i] = 1'b0;
                        continue;
                    end
                    if (peer_probe_at[i] <= b.now) begin
                        diff = 64'(b.now) - 64'(peer_probe_at[i]);
                        if (!peer_pending[i]) begin
                            if (probe_ctr == 0) probe_ctr = 64'd1;
                            peer_pend_id[i] = probe_ctr;
                            peer_pending[i] = 1'b1;
                            probe_ctr = probe_ctr + 64'd1;
                        end
                        r.kind      = KIND_PROBE;
                        r.out_node  = peer_node[i];
                        r.out_conn  = peer_conn[i];
                        r.out_probe = peer_pend_id[i];
                        res.insert(res.size(), r);
                        peer_probe_at[i] = time_sum(48'(64'(peer_probe_at[i])
                                                    + (diff - diff % iv)), iv);
                    end
                end
                r = '0;
                r.kind = KIND_TICK_END;
                r.ok   = 1'b1;
                res.insert(res.size(), r);
            end
            default: res.insert(res.size(), r);
        endcase
        cnt    = 0;
        due    = '0;
        due_ok = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!peer_valid[i]) continue;
            c = (peer_deadline[i] < peer_probe_at[i]) ? peer_deadline[i] : peer_probe_at[i];
            cnt++;
            if (!due_ok || c < due) begin
                due    = c;
                due_ok = 1'b1;
            end
        end
        foreach (res[k]) begin
            res[k].last           = (k == res.size() - 1);
            res[k].peer_count     = 5'(cnt);
            res[k].next_due       = due;
            res[k].next_due_valid = due_ok;
            expected_beats.insert(expected_beats.size(), res[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat e;
        if (!i_rst_n) begin
            interval_q = IVL_RST;
            timeout_q  = TMO_RST;
            probe_ctr  = '0;
            for (int i = 0; i < ENTRIES; i++) begin
                peer_valid[i]   = 1'b0;
                peer_pending[i] = 1'b0;
            end
            expected_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing outstanding: %p", i_out_data);
                    fails++;
                end else begin
                    e = expected_beats.pop_front();
                    check_field("kind", 64'(e.kind), 64'(i_out_data.kind));
                    check_field("ok", 64'(e.ok), 64'(i_out_data.ok));
                    check_field("out_node", e.out_node, i_out_data.out_node);
                    check_field("out_conn", e.out_conn, i_out_data.out_conn);
                    check_field("out_probe", e.out_probe, i_out_data.out_probe);
                    check_field("last", 64'(e.last), 64'(i_out_data.last));
                    check_field("peer_count", 64'(e.peer_count),
                                64'(i_out_data.peer_count));
                    check_field("next_due", 64'(e.next_due), 64'(i_out_data.next_due));
                    check_field("next_due_valid", 64'(e.next_due_valid),
                                64'(i_out_data.next_due_valid));
                end
            end
            if (i_in_valid && i_in_ready) predict_beats(i_in_data);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_TMO) timeout_q = i_pwdata;
                else interval_q = i_pwdata;
            end
        end
    end

    initial fails = 0;

endmodule

FILE: dv/peer_liveness_probe_table_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peer_liveness_probe_table_top_tb: stimulus and verdict for the probe table
// Directed admits, probes, acknowledges, checks and timeouts, then random
// request streams over several register settings with random gaps, a long
// result back-pressure stretch and a drain pause. Checking is in plt_checker.
// ----------------------------------------------------------------------------
module peer_liveness_probe_table_top_tb;
    import plt_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_beat    in_data;
    logic        out_valid;
    logic        out_ready;
    t_out_beat   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          outstanding;
    logic [63:0] last_probe;
    int          cycles;
    logic        long_hold;
    logic        steady;
    logic [63:0] node_pool[24];
    logic [63:0] conn_pool[24];
    logic [47:0] clock_ms;

    peer_liveness_probe_table_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    plt_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_outstanding(outstanding),
        .o_last_probe(last_probe)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stalls, one long hold on request
    initial begin
        int n;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (long_hold) begin
                n = 700;
                long_hold = 1'b0;
            end else begin
                n = steady ? 0 : $urandom_range(0, 3);
            end
            if (n > 0) begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_beat(input logic [2:0] req, input logic [63:0] node,
                             input logic [63:0] conn, input logic [63:0] pid,
                             input logic [47:0] now);
        int gap;
        t_in_beat b;
        b = '{req_type: req, node_id: node, conn_id: conn, probe_tag: pid, now: now};
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_item(input bit ticky);
        int sel;
        int k;
        logic [63:0] pid;
        sel = $urandom_range(0, 99);
        k = $urandom_range(0, 23);
        clock_ms = clock_ms + 48'($urandom_range(0, 1500));
        pid = last_probe - 64'($urandom_range(0, 6));
        if (ticky && sel < 60) sel = 80;
        if (sel < 25) begin
            send_beat(REQ_ADMIT, node_pool[k], conn_pool[k], '0, clock_ms);
        end else if (sel < 35) begin
            send_beat(REQ_DISCONNECT, node_pool[k],
                      ($urandom_range(0, 3) == 0) ? conn_pool[k ^ 1] : conn_pool[k],
                      '0, clock_ms);
        end else if (sel < 55) begin
            send_beat(REQ_ACK, node_pool[k], conn_pool[k], pid, clock_ms);
        end else if (sel < 65) begin
            send_beat(REQ_CHECK, node_pool[k], conn_pool[k],
                      ($urandom_range(0, 4) == 0) ? '0 : pid, clock_ms);
        end else if (sel < 90) begin
            send_beat(REQ_TICK, '0, '0, '0, clock_ms);
        end else begin
            send_beat(3'($urandom_range(0, 7)), {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {16'($urandom), $urandom});
        end
    endtask

    initial begin
        cycles    = 0;
        long_hold = 1'b0;
        steady    = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        clock_ms  = '0;
        for (int i = 0; i < 24; i++) begin
            node_pool[i] = {$urandom, $urandom} | 64'd1;
            conn_pool[i] = {$urandom, $urandom} | 64'd1;
        end
        node_pool[0] = '1;
        conn_pool[0] = '1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill, full, overwrite, probe, ack, check, unknown, timeout
        for (int i = 0; i < ENTRIES; i++) begin
            send_beat(REQ_ADMIT, node_pool[i], conn_pool[i], '0, 48'd0);
        end
        send_beat(REQ_ADMIT, node_pool[20], conn_pool[20], '0, 48'd0);
        send_beat(REQ_ADMIT, '0, conn_pool[20], '0, 48'd0);
        send_beat(REQ_ADMIT, node_pool[3], '0, '0, 48'd0);
        send_beat(REQ_DISCONNECT, node_pool[2], conn_pool[5], '0, 48'd10);
        send_beat(REQ_DISCONNECT, node_pool[2], conn_pool[2], '0, 48'd10);
        send_beat(REQ_TICK, '0, '0, '0, 48'd1500);
        send_beat(REQ_ACK, node_pool[0], conn_pool[0], 64'd1, 48'd1600);
        send_beat(REQ_ACK, node_pool[1], conn_pool[1], 64'd7, 48'd1600);
        send_beat(REQ_ACK, node_pool[20], conn_pool[20], 64'd2, 48'd1600);
        send_beat(REQ_CHECK, node_pool[1], conn_pool[1], 64'd2, 48'd1600);
        send_beat(REQ_CHECK, node_pool[1], conn_pool[1], '0, 48'd1600);
        send_beat(REQ_CHECK, node_pool[21], conn_pool[21], 64'd2, 48'd1600);
        send_beat(3'd5, node_pool[1], conn_pool[1], '1, '1);
        send_beat(3'd7, '1, '1, '1, '1);
        send_beat(REQ_ADMIT, node_pool[4], conn_pool[4], '0, 48'd1700);
        send_beat(REQ_TICK, '0, '0, '0, 48'd2500);
        send_beat(REQ_TICK, '0, '0, '0, 48'd4200);
        drain();

        // random phases over register settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin
                    write_reg(REG_IVL, 32'd1);
                    write_reg(REG_TMO, 32'd2);
                end
                2: begin
                    write_reg(REG_IVL, 32'd0);
                    write_reg(REG_TMO, 32'd5000);
                end
                3: begin
                    write_reg(REG_IVL, 32'hFFFF_FFFF);
                    write_reg(REG_TMO, 32'hFFFF_FFFF);
                    clock_ms = 48'hFFFF_FFFF_0000 + 48'($urandom_range(0, 65535));
                end
                4: begin
                    write_reg(REG_IVL, 32'd700);
                    write_reg(REG_TMO, 32'd2500);
                end
                default: ;
            endcase
            if (ph == 3) begin
                for (int i = 0; i < 8; i++) begin
                    send_beat(REQ_ADMIT, node_pool[i], conn_pool[i], '0, clock_ms);
                end
                clock_ms = 48'hFFFF_FFFF_FFF0;
                send_beat(REQ_TICK, '0, '0, '0, '1);
            end
            steady = (ph == 2);
            for (int n = 0; n < 18; n++) begin
                if (ph == 4 && n == 4) long_hold = 1'b1;
                if (ph == 1 && n == 13) drain();
                random_item(ph == 4 && n >= 4 && n < 16);
            end
            steady = 1'b0;
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
